[sv/rrps_pkg.sv]
// Shared constants, tables, types and helper functions of the ripple ring pixel shader.
package rrps_pkg;

  // Matrix and animation dimensions
  localparam int MATRIX_WIDTH      = 8;
  localparam int MATRIX_HEIGHT     = 8;
  localparam int RING_COUNT        = 4;
  localparam int BRIGHTNESS_LEVELS = 12;

  // Field widths
  localparam int COORD_W    = 3;
  localparam int FRAME_W    = 6;
  localparam int FRAME_MAX  = 63;
  localparam int COLOR_W    = 8;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  // Fixed-point constants (Q12 distances, Q16 exponent)
  localparam int          TIME_STEP_Q12    = 573;
  localparam int          RING_SPACING_Q12 = 3482;
  localparam int          GK_W             = 17;
  localparam logic [16:0] GAUSS_K_Q16      = 17'd108324;
  localparam int          GAUSS_SHIFT      = 24;
  localparam int          FRAC_W           = 16;
  localparam int          EXP_LIMIT        = 10;
  localparam logic [63:0] SAT_BASE         = 64'd30081024;
  localparam logic [63:0] SAT_SLOPE        = 64'd425;
  localparam int          HUE_SECTOR       = 43;
  localparam int          HUE_RESET        = 90;

  // Rounded integer square root, used only to build constants and constant tables
  function automatic logic [63:0] isqrt_round(input logic [63:0] n0);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    int          i;
    n = n0;
    r = '0;
    b = 64'd1 << 62;
    for (i = 0; i < 32; i++) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (n > r) r = r + 64'd1;
    return r;
  endfunction

  // Q12 distance of a pixel from the matrix center
  function automatic logic [63:0] pixel_dist(input int x, input int y);
    longint dx2;
    longint dy2;
    dx2 = 2 * longint'(x) - longint'(MATRIX_WIDTH - 1);
    dy2 = 2 * longint'(y) - longint'(MATRIX_HEIGHT - 1);
    return isqrt_round(64'(dx2 * dx2 + dy2 * dy2) << 22);
  endfunction

  // Derived widths
  localparam logic [63:0] DIST_MAX = pixel_dist(0, 0);
  localparam int DIST_W  = $clog2(DIST_MAX + 64'd1);
  localparam int TQ_MAX  = FRAME_MAX * TIME_STEP_Q12;
  localparam int TQ_W    = $clog2(TQ_MAX + 1);
  localparam int OFF_MAX = (RING_COUNT - 1) * RING_SPACING_Q12;
  localparam int AD_MAX  = (int'(DIST_MAX) + OFF_MAX > TQ_MAX) ?
                           int'(DIST_MAX) + OFF_MAX : TQ_MAX;
  localparam int AD_W    = $clog2(AD_MAX + 1);
  localparam int SD_W    = AD_W + 2;
  localparam int SQ_W    = 2 * AD_W;
  localparam int PR_W    = SQ_W + GK_W;
  localparam int U_W     = PR_W - GAUSS_SHIFT;
  localparam int TERM_W  = FRAC_W + 1;
  localparam int AMP_W   = TERM_W + $clog2(RING_COUNT);
  localparam int LV_W    = $clog2(BRIGHTNESS_LEVELS + 1);
  localparam int PIX_N   = MATRIX_WIDTH * MATRIX_HEIGHT;
  localparam int PIX_W   = $clog2(PIX_N);
  localparam logic [TERM_W-1:0] ONE_Q16 = TERM_W'(1 << FRAC_W);

  // exp(-n) and exp(-f/16), Q16
  localparam logic [TERM_W-1:0] EXP_INT [16] = '{
    17'd65536, 17'd24109, 17'd8869, 17'd3263, 17'd1200, 17'd442, 17'd162, 17'd60,
    17'd22, 17'd8, 17'd3, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0
  };
  localparam logic [TERM_W-1:0] EXP_FRAC [16] = '{
    17'd65536, 17'd61565, 17'd57835, 17'd54331, 17'd51039, 17'd47947, 17'd45042, 17'd42313,
    17'd39750, 17'd37341, 17'd35079, 17'd32954, 17'd30957, 17'd29081, 17'd27319, 17'd25664
  };

  // Per-pixel distance table, indexed by x*MATRIX_HEIGHT + y
  typedef logic [DIST_W-1:0] dist_tab_t [PIX_N];

  function automatic dist_tab_t build_dist_tab();
    dist_tab_t tab;
    int        x;
    int        y;
    for (x = 0; x < MATRIX_WIDTH; x++) begin
      for (y = 0; y < MATRIX_HEIGHT; y++) begin
        tab[x * MATRIX_HEIGHT + y] = DIST_W'(pixel_dist(x, y));
      end
    end
    return tab;
  endfunction

  localparam dist_tab_t DIST_TAB = build_dist_tab();

  // Per-pixel saturation table: falls linearly with distance, floor at zero
  typedef logic [COLOR_W-1:0] sat_tab_t [PIX_N];

  function automatic sat_tab_t build_sat_tab();
    sat_tab_t    tab;
    logic [63:0] satn;
    int          i;
    for (i = 0; i < PIX_N; i++) begin
      satn = 64'(DIST_TAB[i]) * SAT_SLOPE;
      if (satn >= SAT_BASE) tab[i] = '0;
      else tab[i] = COLOR_W'((SAT_BASE - satn + 64'd65536) >> 17);
    end
    return tab;
  endfunction

  localparam sat_tab_t SAT_TAB = build_sat_tab();

  // Gamma-mapped, scaled value for one brightness level (exact wide compare)
  function automatic logic [COLOR_W-1:0] value_of_level(input int level);
    logic [191:0] rhs;
    logic [191:0] lhs;
    int           g;
    int           c;
    int           i;
    int           j;
    rhs = 192'd1;
    for (i = 0; i < 5; i++) rhs = rhs * 192'(9 * level);
    for (i = 0; i < 11; i++) rhs = rhs * 192'd510;
    g = 0;
    for (i = 7; i >= 0; i--) begin
      c = g | (1 << i);
      lhs = 192'd1;
      for (j = 0; j < 11; j++) lhs = lhs * 192'(2 * c - 1);
      for (j = 0; j < 5; j++) lhs = lhs * 192'(10 * BRIGHTNESS_LEVELS);
      if (c <= 255 && lhs <= rhs) g = c;
    end
    return COLOR_W'((g * 250 + 127) / 255);
  endfunction

  typedef logic [COLOR_W-1:0] val_tab_t [BRIGHTNESS_LEVELS + 1];

  function automatic val_tab_t build_val_tab();
    val_tab_t tab;
    int       l;
    for (l = 0; l <= BRIGHTNESS_LEVELS; l++) tab[l] = value_of_level(l);
    return tab;
  endfunction

  localparam val_tab_t VAL_TAB = build_val_tab();

  // x/255 for x up to 255*255
  function automatic logic [COLOR_W-1:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = 17'(x) + 17'(x[15:8]) + 17'd1;
    return s[15:8];
  endfunction

  // Hue sectors of the HSV conversion
  typedef enum logic [2:0] {
    SECT_RED_YEL = 3'd0,
    SECT_YEL_GRN = 3'd1,
    SECT_GRN_CYA = 3'd2,
    SECT_CYA_BLU = 3'd3,
    SECT_BLU_MAG = 3'd4,
    SECT_MAG_RED = 3'd5
  } sector_e;

  function automatic sector_e hue_sector(input logic [COLOR_W-1:0] h);
    sector_e s;
    if (h >= COLOR_W'(5 * HUE_SECTOR))      s = SECT_MAG_RED;
    else if (h >= COLOR_W'(4 * HUE_SECTOR)) s = SECT_BLU_MAG;
    else if (h >= COLOR_W'(3 * HUE_SECTOR)) s = SECT_CYA_BLU;
    else if (h >= COLOR_W'(2 * HUE_SECTOR)) s = SECT_GRN_CYA;
    else if (h >= COLOR_W'(HUE_SECTOR))     s = SECT_YEL_GRN;
    else                                    s = SECT_RED_YEL;
    return s;
  endfunction

  function automatic logic [COLOR_W-1:0] hue_rem(input logic [COLOR_W-1:0] h,
                                                 input sector_e s);
    int r;
    r = (int'(h) - HUE_SECTOR * int'(s)) * 6;
    return COLOR_W'(r);
  endfunction

  // Hue register split into sector and remainder
  typedef struct packed {
    sector_e              sect;
    logic [COLOR_W-1:0]   rem;
  } hue_t;

  localparam sector_e HUE_RESET_SECT = hue_sector(COLOR_W'(HUE_RESET));
  localparam hue_t    HUE_RESET_VAL  = '{
    sect: HUE_RESET_SECT,
    rem:  hue_rem(COLOR_W'(HUE_RESET), HUE_RESET_SECT)
  };

  // Words passed between pipeline sections
  typedef struct packed {
    logic [DIST_W-1:0]  ctr_dist;
    logic [TQ_W-1:0]    tq;
    logic [COLOR_W-1:0] sat;
  } geom_t;

  typedef struct packed {
    logic [RING_COUNT-1:0][TERM_W-1:0] term;
    logic [COLOR_W-1:0]                sat;
  } ring_t;

  typedef struct packed {
    logic [COLOR_W-1:0] val;
    logic [COLOR_W-1:0] sat;
  } shade_t;

endpackage

[sv/rrps_geom.sv]
// Pixel geometry stage: distance and saturation lookup, ring time.
module rrps_geom
  import rrps_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [COORD_W-1:0] x_i,
  input  logic [COORD_W-1:0] y_i,
  input  logic [FRAME_W-1:0] frame_i,
  output logic               valid_o,
  input  logic               ready_i,
  output geom_t              geom_o
);

  logic       vld_q;
  geom_t      geom_d;
  geom_t      geom_q;
  logic [PIX_W-1:0] pix;
  int         xs;
  int         ys;

  assign ready_o = !vld_q || ready_i;

  // clamp coordinates and look up the pixel tables
  always_comb begin
    xs = (int'(x_i) >= MATRIX_WIDTH) ? MATRIX_WIDTH - 1 : int'(x_i);
    ys = (int'(y_i) >= MATRIX_HEIGHT) ? MATRIX_HEIGHT - 1 : int'(y_i);
    pix = PIX_W'(xs * MATRIX_HEIGHT + ys);
    geom_d.ctr_dist = DIST_TAB[pix];
    geom_d.sat      = SAT_TAB[pix];
    geom_d.tq       = TQ_W'(int'(frame_i) * TIME_STEP_Q12);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      geom_q <= geom_d;
    end
  end

  assign valid_o = vld_q;
  assign geom_o  = geom_q;

endmodule

[sv/rrps_gauss.sv]
// Ring Gaussian lanes: one lane per ring, five register stages.
module rrps_gauss
  import rrps_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  geom_t geom_i,
  output logic  valid_o,
  input  logic  ready_i,
  output ring_t ring_o
);

  localparam int GS_STAGES = 5;

  logic [GS_STAGES-1:0] vld_q;
  logic [GS_STAGES-1:0] rdy;
  logic [GS_STAGES-1:0] ld;

  logic [COLOR_W-1:0] sat_q [GS_STAGES];

  // per-lane stage registers
  logic [AD_W-1:0]   ad_d   [RING_COUNT];
  logic [AD_W-1:0]   ad_q   [RING_COUNT];
  logic [SQ_W-1:0]   sq_q   [RING_COUNT];
  logic              far_d  [RING_COUNT];
  logic              far_q  [RING_COUNT];
  logic [3:0]        ei_q   [RING_COUNT];
  logic [3:0]        ef_q   [RING_COUNT];
  logic [11:0]       uf_q   [RING_COUNT];
  logic [TERM_W-1:0] v1_d   [RING_COUNT];
  logic [TERM_W-1:0] v1_q   [RING_COUNT];
  logic [11:0]       uf2_q  [RING_COUNT];
  logic [TERM_W-1:0] term_d [RING_COUNT];
  logic [TERM_W-1:0] term_q [RING_COUNT];

  // stall chain: a stage loads when empty or when its successor moves
  always_comb begin
    rdy[GS_STAGES-1] = !vld_q[GS_STAGES-1] || ready_i;
    for (int i = GS_STAGES - 2; i >= 0; i--) begin
      rdy[i] = !vld_q[i] || rdy[i+1];
    end
    ld[0] = rdy[0] && valid_i;
    for (int i = 1; i < GS_STAGES; i++) begin
      ld[i] = rdy[i] && vld_q[i-1];
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = vld_q[GS_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= valid_i;
      for (int i = 1; i < GS_STAGES; i++) begin
        if (rdy[i]) vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // saturation rides along
  always_ff @(posedge clk_i) begin
    if (ld[0]) sat_q[0] <= geom_i.sat;
    for (int i = 1; i < GS_STAGES; i++) begin
      if (ld[i]) sat_q[i] <= sat_q[i-1];
    end
  end

  for (genvar k = 0; k < RING_COUNT; k++) begin : g_lane
    localparam logic [SD_W-1:0] OFF = SD_W'(k * RING_SPACING_Q12);

    logic [SD_W-1:0] d;
    logic [PR_W-1:0] prod;
    logic [U_W-1:0]  u;
    logic [33:0]     ee;
    logic [33:0]     tt;

    // stage 1: |distance - ring radius|
    always_comb begin
      d = SD_W'(geom_i.ctr_dist) + OFF - SD_W'(geom_i.tq);
      ad_d[k] = d[SD_W-1] ? AD_W'(-d) : AD_W'(d);
    end

    // stage 3: exponent u = d^2 / 0.605 in Q16
    always_comb begin
      prod = PR_W'(sq_q[k]) * PR_W'(GAUSS_K_Q16);
      u = prod[PR_W-1:GAUSS_SHIFT];
      far_d[k] = (u[U_W-1:FRAC_W] > (U_W - FRAC_W)'(EXP_LIMIT));
    end

    // stage 4: integer and coarse fraction parts of exp(-u)
    always_comb begin
      ee = 34'(EXP_INT[ei_q[k]]) * 34'(EXP_FRAC[ef_q[k]]);
      v1_d[k] = far_q[k] ? '0 : TERM_W'(ee >> FRAC_W);
    end

    // stage 5: linear correction for the fine fraction
    always_comb begin
      tt = 34'(v1_q[k]) * 34'(ONE_Q16 - TERM_W'(uf2_q[k]));
      term_d[k] = TERM_W'(tt >> FRAC_W);
    end

    always_ff @(posedge clk_i) begin
      if (ld[0]) ad_q[k] <= ad_d[k];
      if (ld[1]) sq_q[k] <= SQ_W'(ad_q[k]) * SQ_W'(ad_q[k]);
      if (ld[2]) begin
        far_q[k] <= far_d[k];
        ei_q[k]  <= u[FRAC_W+3:FRAC_W];
        ef_q[k]  <= u[15:12];
        uf_q[k]  <= u[11:0];
      end
      if (ld[3]) begin
        v1_q[k]  <= v1_d[k];
        uf2_q[k] <= uf_q[k];
      end
      if (ld[4]) term_q[k] <= term_d[k];
    end

    assign ring_o.term[k] = term_q[k];
  end

  assign ring_o.sat = sat_q[GS_STAGES-1];

endmodule

[sv/rrps_level.sv]
// Amplitude sum, brightness level and gamma-mapped value, two register stages.
module rrps_level
  import rrps_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  ring_t  ring_i,
  output logic   valid_o,
  input  logic   ready_i,
  output shade_t shade_o
);

  logic [1:0]         vld_q;
  logic [1:0]         rdy;
  logic [AMP_W-1:0]   amp_sum;
  logic [TERM_W-1:0]  amp_d;
  logic [TERM_W-1:0]  amp_q;
  logic [COLOR_W-1:0] sat_q;
  logic [31:0]        lvl_full;
  logic [LV_W-1:0]    lvl;
  shade_t             shade_q;

  assign rdy[1]  = !vld_q[1] || ready_i;
  assign rdy[0]  = !vld_q[0] || rdy[1];
  assign ready_o = rdy[0];
  assign valid_o = vld_q[1];

  // sum of ring terms, clipped to one
  always_comb begin
    amp_sum = '0;
    for (int k = 0; k < RING_COUNT; k++) begin
      amp_sum = amp_sum + AMP_W'(ring_i.term[k]);
    end
    amp_d = (amp_sum > AMP_W'(ONE_Q16)) ? ONE_Q16 : TERM_W'(amp_sum);
  end

  // floor to the level count
  always_comb begin
    lvl_full = 32'(amp_q) * 32'(BRIGHTNESS_LEVELS);
    lvl      = LV_W'(lvl_full >> FRAC_W);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= valid_i;
      if (rdy[1]) vld_q[1] <= vld_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i) begin
      amp_q <= amp_d;
      sat_q <= ring_i.sat;
    end
    if (rdy[1] && vld_q[0]) begin
      shade_q.val <= VAL_TAB[lvl];
      shade_q.sat <= sat_q;
    end
  end

  assign shade_o = shade_q;

endmodule

[sv/rrps_hsv.sv]
// Integer HSV to RGB with a fixed hue, two register stages, last one is the output.
module rrps_hsv
  import rrps_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hue_t               hue_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  shade_t             shade_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [COLOR_W-1:0] red_o,
  output logic [COLOR_W-1:0] green_o,
  output logic [COLOR_W-1:0] blue_o
);

  logic [1:0]         vld_q;
  logic [1:0]         rdy;
  logic [COLOR_W-1:0] val_q;
  logic [COLOR_W-1:0] inv_s_q;
  logic [COLOR_W-1:0] sr_q;
  logic [COLOR_W-1:0] st_q;
  logic [COLOR_W-1:0] p;
  logic [COLOR_W-1:0] q;
  logic [COLOR_W-1:0] t;
  logic [COLOR_W-1:0] r_d;
  logic [COLOR_W-1:0] g_d;
  logic [COLOR_W-1:0] b_d;
  logic [COLOR_W-1:0] r_q;
  logic [COLOR_W-1:0] g_q;
  logic [COLOR_W-1:0] b_q;

  assign rdy[1]  = !vld_q[1] || ready_i;
  assign rdy[0]  = !vld_q[0] || rdy[1];
  assign ready_o = rdy[0];
  assign valid_o = vld_q[1];

  // stage 2: p, q, t and sector routing
  always_comb begin
    p = div255(16'(val_q) * 16'(inv_s_q));
    q = div255(16'(val_q) * 16'(8'd255 - sr_q));
    t = div255(16'(val_q) * 16'(8'd255 - st_q));
    unique case (hue_i.sect)
      SECT_YEL_GRN: begin r_d = q;     g_d = val_q; b_d = p;     end
      SECT_GRN_CYA: begin r_d = p;     g_d = val_q; b_d = t;     end
      SECT_CYA_BLU: begin r_d = p;     g_d = q;     b_d = val_q; end
      SECT_BLU_MAG: begin r_d = t;     g_d = p;     b_d = val_q; end
      SECT_MAG_RED: begin r_d = val_q; g_d = p;     b_d = q;     end
      default:      begin r_d = val_q; g_d = t;     b_d = p;     end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= valid_i;
      if (rdy[1]) vld_q[1] <= vld_q[0];
    end
  end

  // stage 1: saturation scaled by the hue remainder
  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i) begin
      val_q   <= shade_i.val;
      inv_s_q <= 8'd255 - shade_i.sat;
      sr_q    <= div255(16'(shade_i.sat) * 16'(hue_i.rem));
      st_q    <= div255(16'(shade_i.sat) * 16'(8'd255 - hue_i.rem));
    end
    if (rdy[1] && vld_q[0]) begin
      r_q <= r_d;
      g_q <= g_d;
      b_q <= b_d;
    end
  end

  assign red_o   = r_q;
  assign green_o = g_q;
  assign blue_o  = b_q;

endmodule

[sv/ripple_ring_pixel_shader.sv]
// Top level of the ripple ring pixel shader: stream ports, hue register, pipeline.
//
// Takes one pixel word (x, y, frame) per clock while the output is not stalled
// and returns its color word: one register stage for the pixel table lookup, five for
// the per-ring Gaussian lanes (multipliers separated by registers), two for
// the amplitude sum and gamma value, two for the HSV conversion, the last of
// which is the output register. Every stage holds its own valid bit, so the
// pipeline keeps accepting words on a stall until its bubbles are filled.
// The hue register is always ready; write it only while no pixel
// is in flight.
module ripple_ring_pixel_shader
  import rrps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config write
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [COLOR_W-1:0]    cfg_data_i,     // hue
  // pixel in
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // pixel_x[2:0], pixel_y[5:3], frame[11:6]
  // color out
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);

  hue_t               hue_q;
  logic               geom_vld;
  logic               geom_rdy;
  geom_t              geom;
  logic               ring_vld;
  logic               ring_rdy;
  ring_t              ring;
  logic               shade_vld;
  logic               shade_rdy;
  shade_t             shade;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;

  // hue register, kept split into sector and remainder
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_q <= HUE_RESET_VAL;
    end else if (cfg_valid_i && cfg_ready_o) begin
      hue_q.sect <= hue_sector(cfg_data_i);
      hue_q.rem  <= hue_rem(cfg_data_i, hue_sector(cfg_data_i));
    end
  end

  rrps_geom u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .x_i     (s_axis_tdata[2:0]),
    .y_i     (s_axis_tdata[5:3]),
    .frame_i (s_axis_tdata[11:6]),
    .valid_o (geom_vld),
    .ready_i (geom_rdy),
    .geom_o  (geom)
  );

  rrps_gauss u_gauss (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (geom_vld),
    .ready_o (geom_rdy),
    .geom_i  (geom),
    .valid_o (ring_vld),
    .ready_i (ring_rdy),
    .ring_o  (ring)
  );

  rrps_level u_level (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ring_vld),
    .ready_o (ring_rdy),
    .ring_i  (ring),
    .valid_o (shade_vld),
    .ready_i (shade_rdy),
    .shade_o (shade)
  );

  rrps_hsv u_hsv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .hue_i   (hue_q),
    .valid_i (shade_vld),
    .ready_o (shade_rdy),
    .shade_i (shade),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .red_o   (red),
    .green_o (green),
    .blue_o  (blue)
  );

  assign m_axis_tdata = {blue, green, red};

endmodule
